>>> src/xor_checked_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame parser
// Shared property shapes, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_PARSER_UNIT_ASSERT_SVH
`define XOR_CHECKED_FRAME_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCFP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("xcfp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define XCFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("xcfp: next-cycle check failed");

`endif

>>> src/xcfp_pkg.sv
// ----------------------------------------------------------------------------
// Frame parser package
// Types, codes and constants shared by the parser front, queue and back end.
// ----------------------------------------------------------------------------
package xcfp_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] HDR_BYTE = 8'hFC;
    localparam logic [7:0] FTR_BYTE = 8'hDF;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_USED_W  = 161;
    localparam int ITEM_DATA_W = 48;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_MOTOR     = 3'd1,
        EV_CH_FIRST  = 3'd2,
        EV_CH_DONE   = 3'd3,
        EV_OTHER     = 3'd4,
        EV_CSUM_ERR  = 3'd5,
        EV_FOOT_ERR  = 3'd6
    } xcfp_event_t;

    typedef enum logic [1:0] {
        REG_MOTOR_CODE  = 2'd0,
        REG_CHAN_FIRST  = 2'd1,
        REG_CHAN_SECOND = 2'd2,
        REG_TIMEOUT     = 2'd3
    } xcfp_reg_t;

    typedef struct packed {
        logic [7:0]  motor_code;
        logic [7:0]  chan_first_code;
        logic [7:0]  chan_second_code;
        logic [31:0] timeout_ms;
    } xcfp_cfg_t;

    localparam xcfp_cfg_t CFG_RESET = '{
        motor_code:       8'h06,
        chan_first_code:  8'h00,
        chan_second_code: 8'h00,
        timeout_ms:       32'd0
    };

    // Classified beat handed from the front to the back end. The data field
    // holds payload bytes zero to five, byte zero in the top bits.
    typedef struct packed {
        xcfp_event_t            evt;
        logic [31:0]            now_ms;
        logic [ITEM_DATA_W-1:0] data;
    } xcfp_item_t;

endpackage

>>> src/xcfp_front.sv
// ----------------------------------------------------------------------------
// Frame parser front
// Tracks the frame position byte by byte, keeps the running XOR and payload,
// and classifies every accepted beat into an event for the back end.
// ----------------------------------------------------------------------------
`include "xor_checked_frame_parser_unit_assert.svh"

module xcfp_front
    import xcfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  xcfp_cfg_t   cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_ms,
    output logic        item_valid,
    input  logic        item_ready,
    output xcfp_item_t  item
);

    localparam int IDX_W = $clog2(PAYLOAD_BYTES);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FUNC,
        PH_DATA,
        PH_CSUM,
        PH_FOOT
    } phase_t;

    phase_t           phase_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       xor_reg;
    logic [7:0]       func_reg;
    logic [7:0]       csum_reg;
    logic [7:0]       store_reg [PAYLOAD_BYTES];
    logic             accept;
    xcfp_event_t      evt_next;

    assign in_ready   = item_ready;
    assign item_valid = in_valid;
    assign accept     = in_valid && item_ready;

    always_comb begin
        evt_next = EV_NONE;
        if (phase_reg == PH_FOOT) begin
            if (rx_byte != FTR_BYTE) begin
                evt_next = EV_FOOT_ERR;
            end else if (xor_reg != csum_reg) begin
                evt_next = EV_CSUM_ERR;
            end else if (func_reg == cfg.motor_code) begin
                evt_next = EV_MOTOR;
            end else if (func_reg == cfg.chan_first_code) begin
                evt_next = EV_CH_FIRST;
            end else if (func_reg == cfg.chan_second_code) begin
                evt_next = EV_CH_DONE;
            end else begin
                evt_next = EV_OTHER;
            end
        end
    end

    assign item.evt    = evt_next;
    assign item.now_ms = now_ms;
    assign item.data   = {store_reg[0], store_reg[1], store_reg[2],
                          store_reg[3], store_reg[4], store_reg[5]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            xor_reg   <= '0;
            func_reg  <= '0;
            csum_reg  <= '0;
        end else if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == HDR_BYTE) begin
                        xor_reg   <= rx_byte;
                        phase_reg <= PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    func_reg  <= rx_byte;
                    xor_reg   <= xor_reg ^ rx_byte;
                    idx_reg   <= '0;
                    phase_reg <= PH_DATA;
                end
                PH_DATA: begin
                    xor_reg <= xor_reg ^ rx_byte;
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(PAYLOAD_BYTES - 1)) begin
                        phase_reg <= PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    csum_reg  <= rx_byte;
                    phase_reg <= PH_FOOT;
                end
                PH_FOOT: begin
                    phase_reg <= PH_HUNT;
                end
                default: begin
                    phase_reg <= PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && phase_reg == PH_DATA) begin
            store_reg[idx_reg] <= rx_byte;
        end
    end

    `XCFP_ASSERT_NEXT(a_foot_returns_to_hunt, accept && phase_reg == PH_FOOT, phase_reg == PH_HUNT)
    `XCFP_ASSERT_SAME(a_event_only_at_footer, phase_reg != PH_FOOT, evt_next == EV_NONE)

endmodule

>>> src/xcfp_queue.sv
// ----------------------------------------------------------------------------
// Frame parser item queue
// Short register queue between the parser front and the back end.
// ----------------------------------------------------------------------------
`include "xor_checked_frame_parser_unit_assert.svh"

module xcfp_queue
    import xcfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  xcfp_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output xcfp_item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    xcfp_item_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `XCFP_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `XCFP_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

>>> src/xcfp_back.sv
// ----------------------------------------------------------------------------
// Frame parser back end
// Applies classified events to the latched speeds, channels, timestamps and
// error count, evaluates link activity and holds the outgoing result beat.
// ----------------------------------------------------------------------------
`include "xor_checked_frame_parser_unit_assert.svh"

module xcfp_back
    import xcfp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  xcfp_cfg_t              cfg,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  xcfp_item_t             item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_user,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic signed [15:0] speed_reg [2];
    logic signed [15:0] chan_reg  [6];
    logic [31:0]        motor_ms_reg;
    logic [31:0]        chan_ms_reg;
    logic               motor_seen_reg;
    logic               chan_seen_reg;
    logic [31:0]        err_reg;
    logic               out_valid_reg;
    logic [2:0]         out_user_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic signed [15:0] speed_next [2];
    logic signed [15:0] chan_next  [6];
    logic [31:0]        motor_ms_next;
    logic [31:0]        chan_ms_next;
    logic               motor_seen_next;
    logic               chan_seen_next;
    logic [31:0]        err_next;
    logic [31:0]        motor_elapsed;
    logic [31:0]        chan_age;
    logic               active_next;
    logic               pop;
    logic               err_pop;
    logic               done_pop;

    assign item_ready = !out_valid_reg || out_ready;
    assign pop        = item_valid && item_ready;
    assign err_pop    = pop && (item.evt == EV_CSUM_ERR || item.evt == EV_FOOT_ERR);
    assign done_pop   = pop && (item.evt == EV_CH_DONE);

    always_comb begin
        speed_next      = speed_reg;
        chan_next       = chan_reg;
        motor_ms_next   = motor_ms_reg;
        chan_ms_next    = chan_ms_reg;
        motor_seen_next = motor_seen_reg;
        chan_seen_next  = chan_seen_reg;
        err_next        = err_reg;
        unique case (item.evt) inside
            EV_MOTOR: begin
                speed_next[0]   = item.data[47:32];
                speed_next[1]   = item.data[31:16];
                motor_ms_next   = item.now_ms;
                motor_seen_next = 1'b1;
            end
            EV_CH_FIRST: begin
                chan_next[0] = item.data[47:32];
                chan_next[1] = item.data[31:16];
                chan_next[2] = item.data[15:0];
                chan_ms_next = item.now_ms;
            end
            EV_CH_DONE: begin
                chan_next[3]   = item.data[47:32];
                chan_next[4]   = item.data[31:16];
                chan_next[5]   = item.data[15:0];
                chan_ms_next   = item.now_ms;
                chan_seen_next = 1'b1;
            end
            EV_CSUM_ERR, EV_FOOT_ERR: begin
                err_next = err_reg + 32'd1;
            end
            default: begin
            end
        endcase
        motor_elapsed = item.now_ms - motor_ms_next;
        chan_age      = item.now_ms - chan_ms_next;
        active_next   = (motor_seen_next && (motor_elapsed < cfg.timeout_ms)) ||
                        (chan_seen_next && (chan_age < cfg.timeout_ms));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg      <= '{default: '0};
            chan_reg       <= '{default: '0};
            motor_ms_reg   <= '0;
            chan_ms_reg    <= '0;
            motor_seen_reg <= 1'b0;
            chan_seen_reg  <= 1'b0;
            err_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                speed_reg      <= speed_next;
                chan_reg       <= chan_next;
                motor_ms_reg   <= motor_ms_next;
                chan_ms_reg    <= chan_ms_next;
                motor_seen_reg <= motor_seen_next;
                chan_seen_reg  <= chan_seen_next;
                err_reg        <= err_next;
                out_valid_reg  <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_user_reg <= item.evt;
            out_data_reg <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, active_next, err_next,
                             chan_next[5], chan_next[4], chan_next[3],
                             chan_next[2], chan_next[1], chan_next[0],
                             speed_next[1], speed_next[0]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_user  = out_user_reg;
    assign out_data  = out_data_reg;

    `XCFP_ASSERT_NEXT(a_error_counts_once, err_pop, err_reg == $past(err_reg) + 32'd1)
    `XCFP_ASSERT_NEXT(a_done_sets_seen, done_pop, chan_seen_reg && out_valid_reg)

endmodule

>>> src/xor_checked_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// XOR-checked serial frame parser
// Takes one received byte with its millisecond tick per input beat and gives
// one result beat for each: the frame event, the latched motor speeds and
// channel values, the error count and the link activity flag. A new byte is
// accepted every cycle; each result is written first into a two-beat queue
// between the parsing front and the latching back end and then into the output
// register, and that queue lets the input keep flowing while a result waits. The
// input stalls only once that queue and the output register are all full.
// Frames are header 0xFC, function byte, PAYLOAD_BYTES payload bytes, the XOR
// of all bytes before it, and footer 0xDF.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_unit
    import xcfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_addr,
    input  logic [31:0]            cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // rx_byte[7:0], now_ms[39:8]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2:0]             m_tuser,   // frame_event[2:0]
    output logic [OUT_TDATA_W-1:0] m_tdata    // left_speed, right_speed,
                                              // chan0..chan5, bad_frames,
                                              // link_active, zero fill
);

    xcfp_cfg_t  cfg_reg;
    logic       front_valid;
    logic       front_ready;
    xcfp_item_t front_item;
    logic       back_valid;
    logic       back_ready;
    xcfp_item_t back_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (xcfp_reg_t'(cfg_addr))
                REG_MOTOR_CODE:  cfg_reg.motor_code       <= cfg_wr_data[7:0];
                REG_CHAN_FIRST:  cfg_reg.chan_first_code  <= cfg_wr_data[7:0];
                REG_CHAN_SECOND: cfg_reg.chan_second_code <= cfg_wr_data[7:0];
                REG_TIMEOUT:     cfg_reg.timeout_ms       <= cfg_wr_data;
            endcase
        end
    end

    xcfp_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .rx_byte   (s_tdata[7:0]),
        .now_ms    (s_tdata[39:8]),
        .item_valid(front_valid),
        .item_ready(front_ready),
        .item      (front_item)
    );

    xcfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(front_valid),
        .push_ready(front_ready),
        .push_item (front_item),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .pop_item  (back_item)
    );

    xcfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .item_valid(back_valid),
        .item_ready(back_ready),
        .item      (back_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_user  (m_tuser),
        .out_data  (m_tdata)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the XOR-checked serial frame parser
// Sends the parser byte streams, each byte with a millisecond tick. Most of
// the stream is whole frames with random payloads and function codes. The
// rest is frames with a bad checksum or a bad footer, cut-off frames and
// noise bytes. The block's registers change between phases. A scoreboard
// class tracks the parser's state and the latched values, and it compares
// every result beat, field by field, with the oldest expected one. Both
// sides of the stream stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import xcfp_pkg::*;

    typedef enum logic [2:0] {
        SEEK_HEADER, TAKE_FUNC, TAKE_DATA, TAKE_SUM, TAKE_FOOTER
    } rx_phase_t;

    typedef enum int {
        FLAW_NONE, FLAW_SUM, FLAW_FOOTER, FLAW_BOTH, FLAW_CUT
    } frame_flaw_t;

    // Layout of the result tdata, from the top bit down.
    typedef struct packed {
        logic [6:0]       fill;
        logic             link_active;
        logic [31:0]      bad_frames;
        logic [5:0][15:0] chan;
        logic [1:0][15:0] speed;
    } status_word_t;

    typedef struct packed {
        xcfp_event_t  evt;
        status_word_t word;
    } parser_result_t;

    class frame_parser_scoreboard;
        logic [7:0]     motor_code, first_code, second_code;
        logic [31:0]    timeout;
        rx_phase_t      phase;
        int             data_count;
        logic [7:0]     check_acc, func_code, sum_byte;
        logic [7:0]     payload [PAYLOAD_BYTES_DEF];
        logic [1:0][15:0] speeds;
        logic [5:0][15:0] chans;
        logic [31:0]    motor_stamp, chan_stamp, fault_total;
        logic           motor_valid, chans_valid;
        parser_result_t expected_results [$];
        int             mismatches;
        int             beats_checked;

        function new();
            motor_code = 8'h06;
            first_code = 8'h00;
            second_code = 8'h00;
            timeout = 32'd0;
            phase = SEEK_HEADER;
            data_count = 0;
            check_acc = 8'h00;
            func_code = 8'h00;
            sum_byte = 8'h00;
            foreach (payload[i]) payload[i] = 8'h00;
            speeds = '0;
            chans = '0;
            motor_stamp = 32'd0;
            chan_stamp = 32'd0;
            fault_total = 32'd0;
            motor_valid = 1'b0;
            chans_valid = 1'b0;
            mismatches = 0;
            beats_checked = 0;
        endfunction

        function void set_reg(xcfp_reg_t idx, logic [31:0] value);
            case (idx)
                REG_MOTOR_CODE:  motor_code = value[7:0];
                REG_CHAN_FIRST:  first_code = value[7:0];
                REG_CHAN_SECOND: second_code = value[7:0];
                REG_TIMEOUT:     timeout = value;
                default: ;
            endcase
        endfunction

        function logic [15:0] word_at(int pos);
            return {payload[pos], payload[pos + 1]};
        endfunction

        // Sorts a frame that passed both checks; the motor code has priority.
        function xcfp_event_t latch_frame(logic [31:0] now);
            if (func_code == motor_code) begin
                speeds[0] = word_at(0);
                speeds[1] = word_at(2);
                motor_stamp = now;
                motor_valid = 1'b1;
                return EV_MOTOR;
            end
            if (func_code == first_code) begin
                chans[0] = word_at(0);
                chans[1] = word_at(2);
                chans[2] = word_at(4);
                chan_stamp = now;
                return EV_CH_FIRST;
            end
            if (func_code == second_code) begin
                chans[3] = word_at(0);
                chans[4] = word_at(2);
                chans[5] = word_at(4);
                chan_stamp = now;
                chans_valid = 1'b1;
                return EV_CH_DONE;
            end
            return EV_OTHER;
        endfunction

        function void take_byte(logic [7:0] rx, logic [31:0] now);
            parser_result_t res;
            logic [31:0] motor_elapsed, chan_age;
            res = '0;
            res.evt = EV_NONE;
            case (phase)
                SEEK_HEADER: begin
                    if (rx == HDR_BYTE) begin
                        check_acc = rx;
                        phase = TAKE_FUNC;
                    end
                end
                TAKE_FUNC: begin
                    func_code = rx;
                    check_acc = check_acc ^ rx;
                    data_count = 0;
                    phase = TAKE_DATA;
                end
                TAKE_DATA: begin
                    payload[data_count] = rx;
                    check_acc = check_acc ^ rx;
                    data_count++;
                    if (data_count >= PAYLOAD_BYTES_DEF) phase = TAKE_SUM;
                end
                TAKE_SUM: begin
                    sum_byte = rx;
                    phase = TAKE_FOOTER;
                end
                default: begin
                    if (rx != FTR_BYTE) begin
                        fault_total++;
                        res.evt = EV_FOOT_ERR;
                    end else if (check_acc != sum_byte) begin
                        fault_total++;
                        res.evt = EV_CSUM_ERR;
                    end else begin
                        res.evt = latch_frame(now);
                    end
                    phase = SEEK_HEADER;
                end
            endcase
            motor_elapsed = now - motor_stamp;
            chan_age = now - chan_stamp;
            res.word.speed = speeds;
            res.word.chan = chans;
            res.word.bad_frames = fault_total;
            res.word.link_active = (motor_valid && motor_elapsed < timeout) ||
                                   (chans_valid && chan_age < timeout);
            expected_results.push_back(res);
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Beat %0d, %s: expected 0x%0h, got 0x%0h",
                             beats_checked, what, want, got);
            end
        endfunction

        function void check_output(logic [2:0] user, status_word_t got);
            parser_result_t want;
            if (expected_results.size() == 0) begin
                compare("result beat with nothing expected", 32'd0, 32'd1);
                beats_checked++;
                return;
            end
            want = expected_results.pop_front();
            compare("frame_event", 32'(want.evt), 32'(user));
            compare("left_speed", 32'(want.word.speed[0]), 32'(got.speed[0]));
            compare("right_speed", 32'(want.word.speed[1]), 32'(got.speed[1]));
            for (int i = 0; i < 6; i++)
                compare($sformatf("chan%0d", i), 32'(want.word.chan[i]), 32'(got.chan[i]));
            compare("bad_frames", want.word.bad_frames, got.bad_frames);
            compare("link_active", 32'(want.word.link_active), 32'(got.link_active));
            beats_checked++;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [1:0]             cfg_addr;
    logic [31:0]            cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [2:0]             m_tuser;
    logic [OUT_TDATA_W-1:0] m_tdata;

    frame_parser_scoreboard sb;
    logic [31:0] tick;
    int          beats_sent;
    bit          sender_idles;
    bit          receiver_idles;

    xor_checked_frame_parser_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [31:0] next_tick();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 2) tick = $urandom;
        else if (pick < 5) tick = tick + $urandom_range(20, 5000);
        else tick = tick + $urandom_range(0, 3);
        return tick;
    endfunction

    task automatic send_byte(input logic [7:0] rx, input logic [31:0] now);
        int gap;
        gap = sender_idles ? int'($urandom_range(0, 11)) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {now, rx};
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(rx, now);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] code, input frame_flaw_t flaw,
                              input logic [63:0] body);
        logic [7:0] stream [$];
        logic [7:0] acc;
        logic [7:0] foot;
        int keep;
        stream = {HDR_BYTE, code};
        for (int i = 0; i < PAYLOAD_BYTES_DEF; i++) stream.push_back(body[63 - 8*i -: 8]);
        acc = 8'h00;
        foreach (stream[i]) acc = acc ^ stream[i];
        if (flaw == FLAW_SUM || flaw == FLAW_BOTH) acc = acc ^ 8'($urandom_range(1, 255));
        stream.push_back(acc);
        foot = FTR_BYTE;
        if (flaw == FLAW_FOOTER || flaw == FLAW_BOTH) begin
            do foot = 8'($urandom_range(0, 255)); while (foot == FTR_BYTE);
        end
        stream.push_back(foot);
        keep = (flaw == FLAW_CUT) ? int'($urandom_range(1, stream.size() - 1))
                                  : stream.size();
        for (int i = 0; i < keep; i++) send_byte(stream[i], next_tick());
    endtask

    // Stops the sender until every expected result beat has arrived.
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input xcfp_reg_t idx, input logic [31:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wr_data = value;
        @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] motor, input logic [7:0] first,
                                  input logic [7:0] second, input logic [31:0] limit);
        write_reg(REG_MOTOR_CODE, {24'd0, motor});
        write_reg(REG_CHAN_FIRST, {24'd0, first});
        write_reg(REG_CHAN_SECOND, {24'd0, second});
        write_reg(REG_TIMEOUT, limit);
    endtask

    // Result side: draws a stall before each beat, then waits for it.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = receiver_idles ? int'($urandom_range(0, 11)) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_output(m_tuser, status_word_t'(m_tdata));
            @(negedge aclk);
        end
    end

    initial begin
        int start_count, pick, phase_end;
        logic [7:0] codes [3];
        logic [7:0] code;
        logic [31:0] limit;
        frame_flaw_t flaw;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_MOTOR_CODE;
        cfg_wr_data = 32'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        tick = 32'd100;
        beats_sent = 0;
        sender_idles = 1'b0;
        receiver_idles = 1'b1;
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset codes: both channel codes are zero, so the first one wins.
        send_frame(8'h06, FLAW_NONE, 64'h7FFF_8000_1234_5678);
        send_frame(8'h00, FLAW_NONE, 64'h8000_7FFF_0000_FFFF);
        send_byte(8'hDF, next_tick());
        send_byte(8'h00, next_tick());
        drain();

        apply_settings(8'h06, 8'h21, 8'h22, 32'hFFFF_FFFF);
        sender_idles = 1'b1;
        send_frame(8'h22, FLAW_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(8'h21, FLAW_NONE, 64'h0000_0000_0000_0000);
        send_frame(8'h5A, FLAW_NONE, 64'h0102_0304_0506_0708);
        send_frame(8'h06, FLAW_SUM, 64'h1111_2222_3333_4444);
        send_frame(8'h06, FLAW_FOOTER, 64'h5555_6666_7777_8888);
        send_frame(8'h06, FLAW_BOTH, 64'hAAAA_BBBB_CCCC_DDDD);
        drain();

        // A short timeout across the wrap of the millisecond tick.
        apply_settings(8'h06, 8'h21, 8'h22, 32'd5);
        tick = 32'hFFFF_FFF8;
        send_frame(8'h06, FLAW_NONE, 64'h0001_FFFE_0000_0000);
        for (int i = 0; i < 8; i++) send_byte(8'h00, tick + i);
        drain();

        apply_settings(8'hFF, 8'hFF, 8'hFF, 32'd1);
        send_frame(8'hFF, FLAW_NONE, 64'h1234_5678_9ABC_DEF0);
        drain();
        apply_settings(8'h00, 8'h80, 8'h80, 32'd40);
        send_frame(8'h80, FLAW_NONE, 64'hFEDC_BA98_7654_3210);
        drain();

        start_count = beats_sent;
        while (beats_sent - start_count < 1650) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) limit = 32'd0;
            else if (pick == 1) limit = 32'd1;
            else if (pick == 2) limit = 32'hFFFF_FFFF;
            else limit = $urandom_range(2, 60);
            for (int i = 0; i < 3; i++) begin
                pick = $urandom_range(0, 5);
                codes[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF
                                                             : 8'($urandom_range(0, 255));
            end
            apply_settings(codes[0], codes[1], codes[2], limit);
            sender_idles = $urandom_range(0, 2) != 0;
            receiver_idles = $urandom_range(0, 2) != 0;
            phase_end = beats_sent + int'($urandom_range(200, 320));
            while (beats_sent < phase_end) begin
                pick = $urandom_range(0, 3);
                code = (pick == 3) ? 8'($urandom_range(0, 255)) : codes[pick];
                pick = $urandom_range(0, 99);
                if (pick < 70) flaw = FLAW_NONE;
                else if (pick < 80) flaw = FLAW_SUM;
                else if (pick < 86) flaw = FLAW_FOOTER;
                else if (pick < 90) flaw = FLAW_BOTH;
                else flaw = FLAW_CUT;
                if (pick >= 95) begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom_range(0, 255)), next_tick());
                end else begin
                    send_frame(code, flaw, {$urandom, $urandom});
                end
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/xcfp_pkg.sv
src/xcfp_front.sv
src/xcfp_queue.sv
src/xcfp_back.sv
src/xor_checked_frame_parser_unit.sv
test/testbench.sv
